### rtl/triangle_heat_element_stiffness_unit_defines.svh
// Assertion macros for the checker file of the stiffness unit.
`ifndef TRIANGLE_HEAT_ELEMENT_STIFFNESS_UNIT_DEFINES_SVH
`define TRIANGLE_HEAT_ELEMENT_STIFFNESS_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define THESU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define THESU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/theat_pkg.sv
// Constants, index tables and saturation helpers for the heat triangle stiffness unit.
`default_nettype none
package theat_pkg;
	localparam int NUM_K     = 6;
	localparam int DIV_STEPS = 33;
	localparam int FRONT     = 7;
	localparam int STAGES    = FRONT + DIV_STEPS + 3;
	localparam int ST_SAT    = FRONT + DIV_STEPS;
	localparam int ST_FP     = ST_SAT + 1;
	localparam int ST_OUT    = ST_SAT + 2;

	// ceil(2^34 / 3): exact floor(n / 3) as (n * MEAN_RECIP) >> 34 for n below 2^33
	localparam logic [32:0] MEAN_RECIP = 33'h1_5555_5556;

	// row and column of each stored upper-triangle entry
	localparam logic [1:0] ROW_IDX [NUM_K] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
	localparam logic [1:0] COL_IDX [NUM_K] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};
	// stored entry for each (row, col) of the full symmetric matrix
	localparam logic [2:0] K_IDX [3][3] = '{'{3'd0, 3'd1, 3'd2},
		'{3'd1, 3'd3, 3'd4}, '{3'd2, 3'd4, 3'd5}};

	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	function automatic logic signed [31:0] sat_q33(input logic neg, input logic ovf,
			input logic [32:0] mag);
		logic signed [31:0] r;
		if (neg) begin
			if (ovf || mag > 33'h0_8000_0000) r = Q_MIN;
			else r = 32'(-$signed(mag));
		end else begin
			if (ovf || mag > 33'h0_7FFF_FFFF) r = Q_MAX;
			else r = 32'(mag);
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat_q50(input logic neg, input logic [49:0] mag);
		logic signed [31:0] r;
		if (neg) begin
			if (mag > 50'h0_8000_0000) r = Q_MIN;
			else r = 32'(-mag);
		end else begin
			if (mag > 50'h0_7FFF_FFFF) r = Q_MAX;
			else r = 32'(mag);
		end
		return r;
	endfunction
endpackage
`default_nettype wire

### rtl/triangle_heat_element_stiffness_unit.sv
// Pipelined conduction stiffness, flux and mean temperature of a linear heat triangle.
//   channel | direction | handshake           | payload
//   in      | input     | in_valid, in_stall   | node coords, thickness, conductivity, temps, want_results
//   out     | output    | out_valid, out_stall | k11..k33, flux1..3, mean_temp, degenerate
// One element enters per cycle while in_stall is low.
// The pipe holds a 33-stage restoring divider, one quotient bit per stage.
// arst_n clears the valid bits only; the payload registers carry no reset.
// A stalled output holds; empty stages keep filling behind it, so in_stall
// rises only when every stage holds an element.
`default_nettype none
module triangle_heat_element_stiffness_unit import theat_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [31:0] node1_x,
	input  wire logic signed [31:0] node1_y,
	input  wire logic signed [31:0] node2_x,
	input  wire logic signed [31:0] node2_y,
	input  wire logic signed [31:0] node3_x,
	input  wire logic signed [31:0] node3_y,
	input  wire logic        [30:0] thickness,
	input  wire logic        [30:0] conductivity,
	input  wire logic signed [31:0] temp_node1,
	input  wire logic signed [31:0] temp_node2,
	input  wire logic signed [31:0] temp_node3,
	input  wire logic               want_results,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed      [31:0] k11,
	output logic signed      [31:0] k12,
	output logic signed      [31:0] k13,
	output logic signed      [31:0] k22,
	output logic signed      [31:0] k23,
	output logic signed      [31:0] k33,
	output logic signed      [31:0] flux1,
	output logic signed      [31:0] flux2,
	output logic signed      [31:0] flux3,
	output logic signed      [31:0] mean_temp,
	output logic                    degenerate
);
	logic [STAGES-1:0] v_q;
	logic [STAGES-1:0] en;

	always_comb begin
		en[STAGES-1] = !v_q[STAGES-1] || !out_stall;
		for (int k = STAGES - 2; k >= 0; k--) en[k] = !v_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int k = 0; k < STAGES; k++) begin
				if (en[k]) v_q[k] <= (k == 0) ? in_valid : v_q[(k == 0) ? 0 : k - 1];
			end
		end
	end

	assign in_stall  = !en[0];
	assign out_valid = v_q[STAGES-1];

	// stage 1: edge differences, thickness times conductivity, temperature sum
	logic signed [32:0] b_s1 [3];
	logic signed [32:0] c_s1 [3];
	logic        [61:0] tk_s1;
	logic signed [31:0] u_s1 [3];
	logic               want_s1;
	logic        [33:0] mx_s1;
	logic               mneg_s1;
	logic signed [33:0] tsum;
	logic        [33:0] tabs;

	always_comb begin
		tsum = 34'(temp_node1) + 34'(temp_node2) + 34'(temp_node3);
		tabs = tsum[33] ? 34'(-tsum) : 34'(tsum);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			b_s1[0] <= 33'(node2_y) - 33'(node3_y);
			b_s1[1] <= 33'(node3_y) - 33'(node1_y);
			b_s1[2] <= 33'(node1_y) - 33'(node2_y);
			c_s1[0] <= 33'(node3_x) - 33'(node2_x);
			c_s1[1] <= 33'(node1_x) - 33'(node3_x);
			c_s1[2] <= 33'(node2_x) - 33'(node1_x);
			tk_s1   <= 62'(thickness) * 62'(conductivity);
			u_s1[0] <= temp_node1;
			u_s1[1] <= temp_node2;
			u_s1[2] <= temp_node3;
			want_s1 <= want_results;
			mx_s1   <= tabs + 34'd1;
			mneg_s1 <= tsum[33];
		end
	end

	// stage 2: edge products; mean magnitude (|sum| + 1) / 3 by reciprocal
	logic signed [65:0] bb_s2 [NUM_K];
	logic signed [65:0] cc_s2 [NUM_K];
	logic signed [65:0] dp1_s2, dp2_s2;
	logic        [61:0] tk_s2;
	logic signed [31:0] u_s2 [3];
	logic               want_s2;
	logic        [33:0] mx_s2;
	logic               mneg_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int e = 0; e < NUM_K; e++) begin
				bb_s2[e] <= b_s1[ROW_IDX[e]] * b_s1[COL_IDX[e]];
				cc_s2[e] <= c_s1[ROW_IDX[e]] * c_s1[COL_IDX[e]];
			end
			dp1_s2  <= c_s1[2] * b_s1[1];
			dp2_s2  <= c_s1[1] * b_s1[2];
			tk_s2   <= tk_s1;
			u_s2    <= u_s1;
			want_s2 <= want_s1;
			mx_s2   <= 34'((67'(mx_s1) * 67'(MEAN_RECIP)) >> 34);
			mneg_s2 <= mneg_s1;
		end
	end

	// stage 3: numerator sums and determinant, as sign and magnitude
	logic signed [66:0] nsum [NUM_K];
	logic signed [66:0] det;
	logic        [65:0] nmag_s3 [NUM_K];
	logic               nneg_s3 [NUM_K];
	logic        [65:0] dmag_s3;
	logic               degen_s3;
	logic        [61:0] tk_s3;
	logic signed [31:0] u_s3 [3];
	logic               want_s3;
	logic        [33:0] mx_s3;
	logic               mneg_s3;

	always_comb begin
		for (int e = 0; e < NUM_K; e++) nsum[e] = 67'(bb_s2[e]) + 67'(cc_s2[e]);
		det = 67'(dp1_s2) - 67'(dp2_s2);
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int e = 0; e < NUM_K; e++) begin
				nmag_s3[e] <= nsum[e][66] ? 66'(-nsum[e]) : 66'(nsum[e]);
				nneg_s3[e] <= nsum[e][66];
			end
			dmag_s3  <= det[66] ? 66'(-det) : 66'(det);
			degen_s3 <= (det == '0);
			tk_s3    <= tk_s2;
			u_s3     <= u_s2;
			want_s3  <= want_s2;
			mx_s3    <= mx_s2;
			mneg_s3  <= mneg_s2;
		end
	end

	// stage 4: partial products of tk times numerator magnitude
	logic [63:0] ll_s4 [NUM_K];
	logic [63:0] lm_s4 [NUM_K];
	logic [33:0] lh_s4 [NUM_K];
	logic [61:0] hl_s4 [NUM_K];
	logic [61:0] hm_s4 [NUM_K];
	logic [31:0] hh_s4 [NUM_K];
	logic               nneg_s4 [NUM_K];
	logic        [65:0] dmag_s4;
	logic               degen_s4;
	logic signed [31:0] u_s4 [3];
	logic               want_s4;
	logic        [33:0] mx_s4;
	logic               mneg_s4;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int e = 0; e < NUM_K; e++) begin
				ll_s4[e] <= 64'(tk_s3[31:0]) * 64'(nmag_s3[e][31:0]);
				lm_s4[e] <= 64'(tk_s3[31:0]) * 64'(nmag_s3[e][63:32]);
				lh_s4[e] <= 34'(tk_s3[31:0]) * 34'(nmag_s3[e][65:64]);
				hl_s4[e] <= 62'(tk_s3[61:32]) * 62'(nmag_s3[e][31:0]);
				hm_s4[e] <= 62'(tk_s3[61:32]) * 62'(nmag_s3[e][63:32]);
				hh_s4[e] <= 32'(tk_s3[61:32]) * 32'(nmag_s3[e][65:64]);
			end
			nneg_s4  <= nneg_s3;
			dmag_s4  <= dmag_s3;
			degen_s4 <= degen_s3;
			u_s4     <= u_s3;
			want_s4  <= want_s3;
			mx_s4    <= mx_s3;
			mneg_s4  <= mneg_s3;
		end
	end

	// stage 5: fold partial products into two rows
	logic [97:0] lo_s5 [NUM_K];
	logic [95:0] hi_s5 [NUM_K];
	logic               nneg_s5 [NUM_K];
	logic        [65:0] dmag_s5;
	logic               degen_s5;
	logic signed [31:0] u_s5 [3];
	logic               want_s5;
	logic        [33:0] mx_s5;
	logic               mneg_s5;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int e = 0; e < NUM_K; e++) begin
				lo_s5[e] <= 98'(ll_s4[e]) + 98'({lm_s4[e], 32'b0}) + {lh_s4[e], 64'b0};
				hi_s5[e] <= 96'(hl_s4[e]) + 96'({hm_s4[e], 32'b0}) + {hh_s4[e], 64'b0};
			end
			nneg_s5  <= nneg_s4;
			dmag_s5  <= dmag_s4;
			degen_s5 <= degen_s4;
			u_s5     <= u_s4;
			want_s5  <= want_s4;
			mx_s5    <= mx_s4;
			mneg_s5  <= mneg_s4;
		end
	end

	// stage 6: full numerator, doubled, plus the rounding half of the divisor
	logic [127:0] num6 [NUM_K];
	logic [128:0] n2_s6 [NUM_K];
	logic               nneg_s6 [NUM_K];
	logic        [65:0] dmag_s6;
	logic               degen_s6;
	logic signed [31:0] u_s6 [3];
	logic               want_s6;
	logic        [33:0] mx_s6;
	logic               mneg_s6;

	always_comb begin
		for (int e = 0; e < NUM_K; e++) num6[e] = 128'(lo_s5[e]) + {hi_s5[e], 32'b0};
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int e = 0; e < NUM_K; e++) begin
				n2_s6[e] <= {num6[e], 1'b0} + 129'({dmag_s5, 17'b0});
			end
			nneg_s6  <= nneg_s5;
			dmag_s6  <= dmag_s5;
			degen_s6 <= degen_s5;
			u_s6     <= u_s5;
			want_s6  <= want_s5;
			mx_s6    <= mx_s5;
			mneg_s6  <= mneg_s5;
		end
	end

	// divider pipeline: index 0 is loaded by stage 7 (overflow check),
	// index t+1 by the step that settles quotient bit DIV_STEPS-1-t
	logic [116:0]       rem_sdv   [DIV_STEPS+1][NUM_K];
	logic [32:0]        quo_sdv   [DIV_STEPS+1][NUM_K];
	logic               ovf_sdv   [DIV_STEPS+1][NUM_K];
	logic               nneg_sdv  [DIV_STEPS+1][NUM_K];
	logic [65:0]        dmag_sdv  [DIV_STEPS+1];
	logic               degen_sdv [DIV_STEPS+1];
	logic signed [31:0] u_sdv     [DIV_STEPS+1][3];
	logic               want_sdv  [DIV_STEPS+1];
	logic [32:0]        mquo_sdv  [DIV_STEPS+1];
	logic               mneg_sdv  [DIV_STEPS+1];

	always_ff @(posedge clk) begin
		if (en[FRONT-1]) begin
			for (int e = 0; e < NUM_K; e++) begin
				ovf_sdv[0][e]  <= n2_s6[e] >= 129'({dmag_s6, 51'b0});
				rem_sdv[0][e]  <= n2_s6[e][116:0];
				quo_sdv[0][e]  <= '0;
				nneg_sdv[0][e] <= nneg_s6[e];
			end
			dmag_sdv[0]  <= dmag_s6;
			degen_sdv[0] <= degen_s6;
			u_sdv[0]     <= u_s6;
			want_sdv[0]  <= want_s6;
			mquo_sdv[0]  <= mx_s6[32:0];
			mneg_sdv[0]  <= mneg_s6;
		end
	end

	for (genvar t = 0; t < DIV_STEPS; t++) begin : g_div
		localparam int QB = DIV_STEPS - 1 - t;
		logic [116:0] dsh;
		assign dsh = 117'({dmag_sdv[t], 18'b0}) << QB;

		always_ff @(posedge clk) begin
			if (en[FRONT+t]) begin
				for (int e = 0; e < NUM_K; e++) begin
					if (rem_sdv[t][e] >= dsh) begin
						rem_sdv[t+1][e] <= rem_sdv[t][e] - dsh;
						quo_sdv[t+1][e] <= quo_sdv[t][e] | (33'd1 << QB);
					end else begin
						rem_sdv[t+1][e] <= rem_sdv[t][e];
						quo_sdv[t+1][e] <= quo_sdv[t][e];
					end
					ovf_sdv[t+1][e]  <= ovf_sdv[t][e];
					nneg_sdv[t+1][e] <= nneg_sdv[t][e];
				end
				dmag_sdv[t+1]  <= dmag_sdv[t];
				degen_sdv[t+1] <= degen_sdv[t];
				u_sdv[t+1]     <= u_sdv[t];
				want_sdv[t+1]  <= want_sdv[t];
				mquo_sdv[t+1]  <= mquo_sdv[t];
				mneg_sdv[t+1]  <= mneg_sdv[t];
			end
		end
	end

	// saturate stiffness entries and mean; zero all results on a flat triangle, and the mean when results are not wanted
	logic signed [31:0] k_sat [NUM_K];
	logic signed [31:0] mean_sat;
	logic signed [31:0] u_sat [3];
	logic               want_sat;
	logic               degen_sat;

	always_ff @(posedge clk) begin
		if (en[ST_SAT]) begin
			for (int e = 0; e < NUM_K; e++) begin
				k_sat[e] <= degen_sdv[DIV_STEPS] ? '0 : sat_q33(nneg_sdv[DIV_STEPS][e],
					ovf_sdv[DIV_STEPS][e], quo_sdv[DIV_STEPS][e]);
			end
			mean_sat  <= (degen_sdv[DIV_STEPS] || !want_sdv[DIV_STEPS]) ? '0 :
				sat_q33(mneg_sdv[DIV_STEPS], 1'b0, mquo_sdv[DIV_STEPS]);
			u_sat     <= u_sdv[DIV_STEPS];
			want_sat  <= want_sdv[DIV_STEPS] && !degen_sdv[DIV_STEPS];
			degen_sat <= degen_sdv[DIV_STEPS];
		end
	end

	// flux products
	logic signed [63:0] fp_sfp [3][3];
	logic signed [31:0] k_sfp [NUM_K];
	logic signed [31:0] mean_sfp;
	logic               want_sfp;
	logic               degen_sfp;

	always_ff @(posedge clk) begin
		if (en[ST_FP]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					fp_sfp[i][j] <= k_sat[K_IDX[i][j]] * u_sat[j];
				end
			end
			k_sfp     <= k_sat;
			mean_sfp  <= mean_sat;
			want_sfp  <= want_sat;
			degen_sfp <= degen_sat;
		end
	end

	// flux sum, round to Q16.16, saturate; output register
	logic signed [65:0] facc [3];
	logic        [65:0] fmag [3];
	logic        [49:0] frnd [3];
	logic signed [31:0] flux_out [3];
	logic signed [31:0] k_out [NUM_K];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			facc[i] = 66'(fp_sfp[i][0]) + 66'(fp_sfp[i][1]) + 66'(fp_sfp[i][2]);
			fmag[i] = facc[i][65] ? 66'(-facc[i]) : 66'(facc[i]);
			frnd[i] = 50'((fmag[i] + 66'd32768) >> 16);
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_OUT]) begin
			for (int i = 0; i < 3; i++) begin
				flux_out[i] <= want_sfp ? sat_q50(facc[i][65], frnd[i]) : '0;
			end
			k_out      <= k_sfp;
			mean_temp  <= mean_sfp;
			degenerate <= degen_sfp;
		end
	end

	assign k11   = k_out[0];
	assign k12   = k_out[1];
	assign k13   = k_out[2];
	assign k22   = k_out[3];
	assign k23   = k_out[4];
	assign k33   = k_out[5];
	assign flux1 = flux_out[0];
	assign flux2 = flux_out[1];
	assign flux3 = flux_out[2];
endmodule
`default_nettype wire

### rtl/theat_chk.sv
// Port-level checker for the heat triangle stiffness unit, with its bind.
`default_nettype none
`include "triangle_heat_element_stiffness_unit_defines.svh"
module theat_chk (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic signed [31:0] k11,
	input wire logic signed [31:0] k12,
	input wire logic signed [31:0] k13,
	input wire logic signed [31:0] k22,
	input wire logic signed [31:0] k23,
	input wire logic signed [31:0] k33,
	input wire logic signed [31:0] flux1,
	input wire logic signed [31:0] mean_temp,
	input wire logic               degenerate
);
	`THESU_ASSERT_NOW(a_flat_zero, out_valid && degenerate, k11 == 0 && k12 == 0 && k13 == 0 && k22 == 0 && k23 == 0 && k33 == 0 && flux1 == 0 && mean_temp == 0, "flat triangle gave nonzero outputs")
	`THESU_ASSERT_NOW(a_diag_nonneg, out_valid, !k11[31] && !k22[31] && !k33[31], "negative diagonal stiffness")
	`THESU_ASSERT_NOW(a_stall_full, in_stall, out_valid && out_stall, "input stalled with output free")
	`THESU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(k12) && $stable(degenerate), "stalled result changed")
endmodule

bind triangle_heat_element_stiffness_unit theat_chk u_theat_chk (.*);
`default_nettype wire

### tb/triangle_heat_element_stiffness_checker.sv
// Watches both channels of the stiffness unit, predicts each element's result and compares it.
`timescale 1ns / 1ps
`default_nettype none
module triangle_heat_element_stiffness_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire logic signed [31:0] node1_x,
	input  wire logic signed [31:0] node1_y,
	input  wire logic signed [31:0] node2_x,
	input  wire logic signed [31:0] node2_y,
	input  wire logic signed [31:0] node3_x,
	input  wire logic signed [31:0] node3_y,
	input  wire logic        [30:0] thickness,
	input  wire logic        [30:0] conductivity,
	input  wire logic signed [31:0] temp_node1,
	input  wire logic signed [31:0] temp_node2,
	input  wire logic signed [31:0] temp_node3,
	input  wire logic               want_results,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire logic signed [31:0] k11,
	input  wire logic signed [31:0] k12,
	input  wire logic signed [31:0] k13,
	input  wire logic signed [31:0] k22,
	input  wire logic signed [31:0] k23,
	input  wire logic signed [31:0] k33,
	input  wire logic signed [31:0] flux1,
	input  wire logic signed [31:0] flux2,
	input  wire logic signed [31:0] flux3,
	input  wire logic signed [31:0] mean_temp,
	input  wire logic               degenerate,
	output int                      fail_count,
	output int                      pending,
	output int                      checked,
	output int                      degen_seen
);
	typedef logic signed [255:0] wide_t;

	typedef struct packed {
		logic signed [31:0] k11, k12, k13, k22, k23, k33;
		logic signed [31:0] flux1, flux2, flux3, mean_temp;
		logic               degenerate;
	} stiff_t;

	stiff_t expected_q[$];

	// round num/den to nearest, ties away from zero, then clamp to Q16.16
	function automatic logic signed [31:0] round_sat(wide_t num, wide_t den);
		logic  neg;
		wide_t mag;
		wide_t q;
		neg = num < 0;
		mag = neg ? -num : num;
		q = (2 * mag + den) / (2 * den);
		if (neg) return (q > 256'sh8000_0000) ? 32'sh8000_0000 : 32'(-q);
		return (q > 256'sh7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(q);
	endfunction

	function automatic stiff_t conduction_stiffness(
			logic signed [31:0] ax1, ay1, ax2, ay2, ax3, ay3,
			logic [30:0] th, kc, logic signed [31:0] u1, u2, u3, logic w);
		stiff_t r;
		wide_t x1, y1, x2, y2, x3, y3, det, den, tk;
		wide_t b[3];
		wide_t c[3];
		wide_t u[3];
		logic signed [31:0] k[3][3];
		wide_t acc;
		int rr, cc;
		r = '0;
		x1 = ax1; y1 = ay1; x2 = ax2; y2 = ay2; x3 = ax3; y3 = ay3;
		u[0] = u1; u[1] = u2; u[2] = u3;
		b[0] = y2 - y3; b[1] = y3 - y1; b[2] = y1 - y2;
		c[0] = x3 - x2; c[1] = x1 - x3; c[2] = x2 - x1;
		det = (x2 - x1) * (y3 - y1) - (x3 - x1) * (y2 - y1);
		if (det == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		den = (det < 0 ? -det : det) <<< 17;
		tk = wide_t'(th) * wide_t'(kc);
		for (rr = 0; rr < 3; rr++)
			for (cc = rr; cc < 3; cc++) begin
				k[rr][cc] = round_sat(tk * (b[rr] * b[cc] + c[rr] * c[cc]), den);
				k[cc][rr] = k[rr][cc];
			end
		r.k11 = k[0][0]; r.k12 = k[0][1]; r.k13 = k[0][2];
		r.k22 = k[1][1]; r.k23 = k[1][2]; r.k33 = k[2][2];
		if (w) begin
			for (rr = 0; rr < 3; rr++) begin
				acc = 0;
				for (cc = 0; cc < 3; cc++) acc += wide_t'(k[rr][cc]) * u[cc];
				case (rr)
					0: r.flux1 = round_sat(acc, 65536);
					1: r.flux2 = round_sat(acc, 65536);
					default: r.flux3 = round_sat(acc, 65536);
				endcase
			end
			r.mean_temp = round_sat(u[0] + u[1] + u[2], 3);
		end
		return r;
	endfunction

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d (0x%08h), got %0d (0x%08h)", name,
				$signed(want), want, $signed(got), got);
			fail_count++;
		end
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		checked = 0;
		degen_seen = 0;
	end

	always @(posedge clk) begin
		stiff_t e;
		if (arst_n && in_valid && !in_stall)
			expected_q.push_back(conduction_stiffness(node1_x, node1_y, node2_x, node2_y,
				node3_x, node3_y, thickness, conductivity, temp_node1, temp_node2,
				temp_node3, want_results));
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$error("result transfer with no element outstanding");
				fail_count++;
			end else begin
				e = expected_q.pop_front();
				checked++;
				if (e.degenerate) degen_seen++;
				compare_field("k11", e.k11, k11);
				compare_field("k12", e.k12, k12);
				compare_field("k13", e.k13, k13);
				compare_field("k22", e.k22, k22);
				compare_field("k23", e.k23, k23);
				compare_field("k33", e.k33, k33);
				compare_field("flux1", e.flux1, flux1);
				compare_field("flux2", e.flux2, flux2);
				compare_field("flux3", e.flux3, flux3);
				compare_field("mean_temp", e.mean_temp, mean_temp);
				compare_field("degenerate", 32'(e.degenerate), 32'(degenerate));
			end
		end
		pending = expected_q.size();
	end
endmodule
`default_nettype wire

### tb/tb_triangle_heat_element_stiffness_unit.sv
// Top of the stiffness unit testbench: clock, reset, element stimulus, output stalls, verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_triangle_heat_element_stiffness_unit;
	localparam int NUM_RANDOM  = 1030;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] node1_x = '0, node1_y = '0, node2_x = '0, node2_y = '0;
	logic signed [31:0] node3_x = '0, node3_y = '0;
	logic [30:0] thickness = '0, conductivity = '0;
	logic signed [31:0] temp_node1 = '0, temp_node2 = '0, temp_node3 = '0;
	logic want_results = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] k11, k12, k13, k22, k23, k33, flux1, flux2, flux3, mean_temp;
	logic degenerate;

	int fail_count, pending, checked, degen_seen;
	int elems_sent = 0;
	int cycles = 0;
	logic in_xfer = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	triangle_heat_element_stiffness_unit uut (.*);

	triangle_heat_element_stiffness_checker chk (.*);

	always @(posedge clk) in_xfer <= in_valid && !in_stall;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("triangle_heat_element_stiffness_unit: mismatch");
			$finish;
		end
	end

	// hold the element until it transfers
	task automatic send_elem(logic signed [31:0] x1, y1, x2, y2, x3, y3,
			logic [30:0] th, kc, logic signed [31:0] u1, u2, u3, logic w);
		@(negedge clk);
		node1_x <= x1; node1_y <= y1; node2_x <= x2; node2_y <= y2;
		node3_x <= x3; node3_y <= y3; thickness <= th; conductivity <= kc;
		temp_node1 <= u1; temp_node2 <= u2; temp_node3 <= u3; want_results <= w;
		in_valid <= 1'b1;
		forever begin
			@(posedge clk);
			#1;
			if (in_xfer) break;
		end
		elems_sent++;
	endtask

	function automatic logic signed [31:0] rand_coord(int mode);
		case (mode)
			0: return $urandom;
			1: return $signed(20'($urandom)) ;
			default: return $urandom_range(2) == 0 ? 32'sh7FFF_FFFF :
				($urandom_range(1) == 0 ? 32'sh8000_0000 : 32'sh0);
		endcase
	endfunction

	task automatic send_random();
		int mode;
		logic signed [31:0] x[3];
		logic signed [31:0] y[3];
		logic [30:0] th, kc;
		int i;
		mode = $urandom_range(9);
		for (i = 0; i < 3; i++) begin
			x[i] = rand_coord(mode < 3 ? 0 : (mode < 9 ? 1 : 2));
			y[i] = rand_coord(mode < 3 ? 0 : (mode < 9 ? 1 : 2));
		end
		// collapse the triangle now and then
		if ($urandom_range(11) == 0) begin
			x[2] = x[$urandom_range(1)];
			y[2] = y[$urandom_range(1)];
			if ($urandom_range(1)) begin x[1] = x[0]; y[1] = y[0]; end
		end
		th = $urandom_range(1) ? 31'($urandom) : 31'($urandom_range(32'h4_0000));
		kc = $urandom_range(1) ? 31'($urandom) : 31'($urandom_range(32'h4_0000));
		send_elem(x[0], y[0], x[1], y[1], x[2], y[2], th, kc,
			$urandom_range(1) ? $signed($urandom) : $signed(24'($urandom)),
			$urandom_range(1) ? $signed($urandom) : $signed(24'($urandom)),
			$urandom_range(1) ? $signed($urandom) : $signed(24'($urandom)),
			$urandom_range(3) != 0);
	endtask

	// receiver: random stall regimes plus one long hold-off so the pipe fills
	initial begin
		int regime, span;
		bit held;
		held = 1'b0;
		wait (arst_n);
		forever begin
			if (!held && elems_sent >= 300) begin
				@(negedge clk) out_stall <= 1'b1;
				repeat (150) @(negedge clk);
				held = 1'b1;
			end
			regime = $urandom_range(2);
			span = $urandom_range(20, 120);
			repeat (span) begin
				@(negedge clk);
				case (regime)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(9) < 3);
					default: out_stall <= ($urandom_range(9) < 7);
				endcase
			end
		end
	end

	initial begin
		int burst, gap, n;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// corners: unit triangle, extremes, collapsed triangles, zero and max material
		send_elem(0, 0, 32'sh1_0000, 0, 0, 32'sh1_0000, 31'h1_0000, 31'h1_0000,
			32'sh1_0000, 32'sh2_0000, 32'sh3_0000, 1);
		send_elem(0, 0, 32'sh1_0000, 0, 0, 32'sh1_0000, 31'h1_0000, 31'h1_0000,
			32'sh1_0000, 32'sh2_0000, 32'sh3_0000, 0);
		send_elem(0, 0, 0, 32'sh1_0000, 32'sh1_0000, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
			32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1);
		send_elem(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
			32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1);
		send_elem(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF, 32'sh8000_0000, 31'h1, 31'h1,
			32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1);
		send_elem(0, 0, 0, 0, 0, 0, 31'h1_0000, 31'h1_0000, 5, 6, 7, 1);
		send_elem(32'sh5_0000, 32'sh3_0000, 32'sh5_0000, 32'sh3_0000, 1, 2,
			31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, 1, 2, 1);
		send_elem(0, 0, 32'sh1_0000, 32'sh1_0000, 32'sh2_0000, 32'sh2_0000,
			31'h1_0000, 31'h1_0000, 1, 2, 3, 0);
		send_elem(0, 0, 32'sh2_0000, 0, 0, 32'sh3_0000, 0, 31'h7FFF_FFFF,
			32'sh1_0000, -32'sh1_0000, 0, 1);
		send_elem(0, 0, 32'sh2_0000, 0, 0, 32'sh3_0000, 31'h7FFF_FFFF, 0,
			32'sh1_0000, -32'sh1_0000, 0, 1);
		send_elem(0, 0, 1, 0, 0, 1, 31'h7FFF_FFFF, 31'h7FFF_FFFF, -1, -1, -1, 1);
		send_elem(0, 0, 1, 0, 0, 1, 31'h1, 31'h1, -1, -1, 0, 1);
		send_elem(0, 0, 0, 1, 1, 0, 31'h3, 31'h5, -2, 1, 0, 1);
		send_elem(32'sh10_0000, -32'sh10_0000, -32'sh20_0000, 32'sh3_8000,
			32'sh7_4000, 32'sh11_0001, 31'h2_8000, 31'h0_C000,
			32'sh64_0000, -32'sh32_0000, 32'sh19_0000, 1);
		@(negedge clk) in_valid <= 1'b0;

		n = 0;
		while (n < NUM_RANDOM) begin
			burst = ($urandom_range(4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
			repeat (burst) begin
				send_random();
				n++;
			end
			gap = $urandom_range(3) == 0 ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				@(negedge clk) in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk) in_valid <= 1'b0;

		wait (pending == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("sent %0d elements, %0d results checked, %0d of them degenerate",
			elems_sent, checked, degen_seen);
		$display("input and output stalls in bursts, with one long output hold-off");
		if (fail_count == 0 && pending == 0)
			$display("triangle_heat_element_stiffness_unit: match");
		else
			$display("triangle_heat_element_stiffness_unit: mismatch");
		$finish;
	end
endmodule
`default_nettype wire
